@@ rtl/mdm_pkg.sv @@
// Shared definitions for the multiply / divide / accumulate unit.
// Register map codes, accumulator width, state types and the request
// struct passed to the iterative arithmetic unit. No dependencies.
package mdm_pkg;

   localparam int AccWidth     = 40;
   localparam int OperandWidth = 16;
   localparam int ProdWidth    = 2 * OperandWidth;
   localparam int StepCount    = OperandWidth;
   localparam int CountWidth   = $clog2(StepCount);

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [3:0] REG_CTRL   = 4'd0;
   localparam logic [3:0] REG_A_LO   = 4'd1;
   localparam logic [3:0] REG_A_HI   = 4'd2;
   localparam logic [3:0] REG_B_LO   = 4'd3;
   localparam logic [3:0] REG_B_HI   = 4'd4;
   localparam logic [3:0] REG_RES_0  = 4'd5;
   localparam logic [3:0] REG_RES_1  = 4'd6;
   localparam logic [3:0] REG_RES_2  = 4'd7;
   localparam logic [3:0] REG_RES_3  = 4'd8;
   localparam logic [3:0] REG_RES_4  = 4'd9;
   localparam logic [3:0] REG_OVF    = 4'd10;

   localparam int CTRL_DIVIDE_BIT = 0;
   localparam int CTRL_SUM_BIT    = 1;

   localparam logic [7:0] OVF_SET_BYTE = 8'h80;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_RUN,
      ALU_FIX
   } alu_state_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_BUSY
   } top_state_type;

   typedef struct packed {
      logic start;
      logic divide;
   } alu_req_type;

endpackage

@@ rtl/mdm_alu.sv @@
// Iterative shift-add multiplier and restoring divider sharing one adder.
// Signed 16x16 multiply, or signed-by-unsigned floored divide with the
// remainder in the upper half. Depends on mdm_pkg.
module mdm_alu (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mdm_pkg::alu_req_type                   alu_req,
   input  logic [mdm_pkg::OperandWidth-1:0]       operand_a,
   input  logic [mdm_pkg::OperandWidth-1:0]       operand_b,
   output logic                                   done,
   output logic [mdm_pkg::ProdWidth-1:0]          result
);

   localparam int W = mdm_pkg::OperandWidth;

   mdm_pkg::alu_state_type state_ff, state_in;
   logic [mdm_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic [W:0]   hi_ff, hi_in;
   logic [W-1:0] lo_ff, lo_in;
   logic [W-1:0] y_ff, y_in;
   logic [W-1:0] a_raw_ff, a_raw_in;
   logic         neg_ff, neg_in;
   logic         div_ff, div_in;
   logic         done_ff, done_in;
   logic [mdm_pkg::ProdWidth-1:0] result_ff, result_in;

   logic [W:0]   adder_x;
   logic [W+1:0] adder_y;
   logic [W+1:0] adder_sum;
   logic [W-1:0] a_mag;
   logic [W-1:0] b_mag;
   logic [mdm_pkg::ProdWidth-1:0] mag_prod;

   assign a_mag = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
   assign b_mag = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;
   assign mag_prod = {hi_ff[W-1:0], lo_ff};

   // The one adder: add the multiplicand for a multiply step, subtract the
   // divisor for a divide step.
   always_comb begin
      if (div_ff) begin
         adder_x = {hi_ff[W-1:0], lo_ff[W-1]};
         adder_y = ~{2'b00, y_ff};
      end else begin
         adder_x = {1'b0, hi_ff[W-1:0]};
         adder_y = lo_ff[0] ? {2'b00, y_ff} : '0;
      end
      adder_sum = {1'b0, adder_x} + adder_y + {{(W+1){1'b0}}, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdm_pkg::ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      y_ff      <= y_in;
      a_raw_ff  <= a_raw_in;
      neg_ff    <= neg_in;
      div_ff    <= div_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      y_in      = y_ff;
      a_raw_in  = a_raw_ff;
      neg_in    = neg_ff;
      div_in    = div_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (state_ff)
         mdm_pkg::ALU_IDLE: begin
            if (alu_req.start) begin
               state_in = mdm_pkg::ALU_RUN;
               cnt_in   = '1;
               hi_in    = '0;
               lo_in    = a_mag;
               a_raw_in = operand_a;
               div_in   = alu_req.divide;
               if (alu_req.divide) begin
                  y_in   = operand_b;
                  neg_in = operand_a[W-1];
               end else begin
                  y_in   = b_mag;
                  neg_in = operand_a[W-1] ^ operand_b[W-1];
               end
            end
         end
         mdm_pkg::ALU_RUN: begin
            if (div_ff) begin
               // A clear borrow bit means the divisor fitted.
               if (!adder_sum[W+1]) begin
                  hi_in = adder_sum[W:0];
               end else begin
                  hi_in = adder_x;
               end
               lo_in = {lo_ff[W-2:0], ~adder_sum[W+1]};
            end else begin
               hi_in = {1'b0, adder_sum[W:1]};
               lo_in = {adder_sum[0], lo_ff[W-1:1]};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = mdm_pkg::ALU_FIX;
            end
         end
         mdm_pkg::ALU_FIX: begin
            state_in = mdm_pkg::ALU_IDLE;
            done_in  = 1'b1;
            if (!div_ff) begin
               result_in = neg_ff ? (~mag_prod + 1'b1) : mag_prod;
            end else if (y_ff == '0) begin
               result_in = {a_raw_ff, {W{1'b0}}};
            end else if (!neg_ff) begin
               result_in = {hi_ff[W-1:0], lo_ff};
            end else if (hi_ff[W-1:0] == '0) begin
               result_in = {{W{1'b0}}, ~lo_ff + 1'b1};
            end else begin
               // Floor for a negative dividend: step the quotient down by one
               // and take the remainder from the divisor.
               result_in = {y_ff - hi_ff[W-1:0], ~lo_ff};
            end
         end
         default: begin
            state_in = mdm_pkg::ALU_IDLE;
         end
      endcase
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ rtl/mul_div_mac_unit_top.sv @@
// Top level of the multiply / divide / accumulate unit: register port,
// accumulator and result channel. Depends on mdm_pkg and mdm_alu.
//
// Usage: each item on the req_ channel is one register access (read or
// write of an 8-bit register). Every item returns exactly one item on the
// rsp_ channel carrying rsp_read_data, which is zero for writes.
// Register reads and writes other than the high byte of B are answered
// in the cycle after acceptance. Writing the high byte of B starts the
// selected operation in the shared iterative unit: the operands load at the
// accepting edge, then sixteen add-and-shift steps run through a single
// 18-bit adder, then the fix-up state and the registered reply. The unit
// handles one item at a time; req_stall stays high while an operation runs.
// The reply sits in an output register, so a new item may be accepted as
// soon as that reply is being taken. While rsp_stall is high the reply
// holds and req_stall is raised.
// Reset clears the control bits, operands, accumulator and overflow flag
// and drops any pending reply.
module mul_div_mac_unit_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [3:0] req_reg_select,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data
);

   localparam int AW = mdm_pkg::AccWidth;
   localparam int OW = mdm_pkg::OperandWidth;
   localparam int PW = mdm_pkg::ProdWidth;

   mdm_pkg::top_state_type state_ff, state_in;
   logic          sum_mode_ff, sum_mode_in;
   logic          divide_mode_ff, divide_mode_in;
   logic [OW-1:0] operand_a_ff, operand_a_in;
   logic [OW-1:0] operand_b_ff, operand_b_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;

   mdm_pkg::alu_req_type alu_req;
   logic          alu_done;
   logic [PW-1:0] alu_result;
   logic [OW-1:0] alu_b;
   logic          accept;
   logic [63:0]   acc_ext;
   logic [7:0]    read_byte;
   logic [AW:0]   acc_sum;

   mdm_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .alu_req   (alu_req),
      .operand_a (operand_a_ff),
      .operand_b (alu_b),
      .done      (alu_done),
      .result    (alu_result)
   );

   assign req_stall = (state_ff != mdm_pkg::TOP_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign alu_b     = {req_write_data, operand_b_ff[7:0]};

   always_comb begin
      alu_req.start  = accept && (req_opcode == mdm_pkg::OP_WRITE)
                       && (req_reg_select == mdm_pkg::REG_B_HI);
      alu_req.divide = divide_mode_ff && !sum_mode_ff;
   end

   // The accumulator plus the sign-extended product, one bit wider: the top
   // bit flags both a carry past the width and a negative true sum.
   assign acc_sum = {1'b0, acc_ff} + {{(AW + 1 - PW){alu_result[PW-1]}}, alu_result};

   always_comb begin
      acc_ext = '0;
      acc_ext[AW-1:0] = acc_ff;
      case (req_reg_select)
         mdm_pkg::REG_RES_0: read_byte = acc_ext[7:0];
         mdm_pkg::REG_RES_1: read_byte = acc_ext[15:8];
         mdm_pkg::REG_RES_2: read_byte = acc_ext[23:16];
         mdm_pkg::REG_RES_3: read_byte = acc_ext[31:24];
         mdm_pkg::REG_RES_4: read_byte = acc_ext[39:32];
         mdm_pkg::REG_OVF:   read_byte = ovf_ff ? mdm_pkg::OVF_SET_BYTE : 8'h00;
         default:            read_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mdm_pkg::TOP_IDLE;
         sum_mode_ff    <= 1'b0;
         divide_mode_ff <= 1'b0;
         operand_a_ff   <= '0;
         operand_b_ff   <= '0;
         acc_ff         <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sum_mode_ff    <= sum_mode_in;
         divide_mode_ff <= divide_mode_in;
         operand_a_ff   <= operand_a_in;
         operand_b_ff   <= operand_b_in;
         acc_ff         <= acc_in;
         ovf_ff         <= ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in       = state_ff;
      sum_mode_in    = sum_mode_ff;
      divide_mode_in = divide_mode_ff;
      operand_a_in   = operand_a_ff;
      operand_b_in   = operand_b_ff;
      acc_in         = acc_ff;
      ovf_in         = ovf_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         mdm_pkg::TOP_IDLE: begin
            if (accept) begin
               if (req_opcode == mdm_pkg::OP_WRITE) begin
                  case (req_reg_select)
                     mdm_pkg::REG_CTRL: begin
                        divide_mode_in = req_write_data[mdm_pkg::CTRL_DIVIDE_BIT];
                        sum_mode_in    = req_write_data[mdm_pkg::CTRL_SUM_BIT];
                        if (req_write_data[mdm_pkg::CTRL_SUM_BIT]) begin
                           acc_in = '0;
                           ovf_in = 1'b0;
                        end
                     end
                     mdm_pkg::REG_A_LO: operand_a_in[7:0]  = req_write_data;
                     mdm_pkg::REG_A_HI: operand_a_in[15:8] = req_write_data;
                     mdm_pkg::REG_B_LO: operand_b_in[7:0]  = req_write_data;
                     default: ;
                  endcase
               end
               if (alu_req.start) begin
                  state_in = mdm_pkg::TOP_BUSY;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = (req_opcode == mdm_pkg::OP_WRITE) ? 8'h00 : read_byte;
               end
            end
         end
         mdm_pkg::TOP_BUSY: begin
            if (alu_done) begin
               state_in     = mdm_pkg::TOP_IDLE;
               operand_b_in = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = 8'h00;
               if (sum_mode_ff) begin
                  acc_in = acc_sum[AW-1:0];
                  ovf_in = ovf_ff | acc_sum[AW];
               end else begin
                  acc_in = {{(AW - PW){1'b0}}, alu_result};
               end
            end
         end
         default: begin
            state_in = mdm_pkg::TOP_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule
